// ----- rtl/core/dcd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dcd_pkg
// Shared constants, controller states and the command and status bundles
// that join the controller to the datapath of the directed cycle detector.
// ----------------------------------------------------------------------------
package dcd_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int NODE_W        = 6;
    localparam int CFG_W         = 7;

    localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_CHECK    = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_RD,
        S_EDGE_WR,
        S_CLEAR,
        S_SCAN,
        S_ROW_RD,
        S_ROW_EVAL,
        S_PICK,
        S_POP_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic latch_edge;
        logic edge_rd;
        logic edge_wr;
        logic clear;
        logic scan_skip;
        logic scan_push;
        logic row_rd;
        logic row_eval;
        logic push_child;
        logic pop;
        logic pop_load;
        logic load_result;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic start_visited;
        logic cycle;
        logic cand_zero;
        logic depth_one;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ----- rtl/core/dcd_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dcd_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module dcd_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/dcd_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dcd_datapath
// Adjacency row memory with row valid bits, visited and on-path marks,
// path stack memory, start scan counter and the result register.
// ----------------------------------------------------------------------------
module dcd_datapath #(
    parameter int MAX_NODES = dcd_pkg::MAX_NODES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire dcd_pkg::t_cmd              i_cmd,
    output dcd_pkg::t_status                o_status,
    input  wire logic [dcd_pkg::NODE_W-1:0] i_edge_from,
    input  wire logic [dcd_pkg::NODE_W-1:0] i_edge_to,
    input  wire logic                       i_cfg_valid,
    input  wire logic [dcd_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_out_data
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = ($clog2(MAX_NODES + 1) > dcd_pkg::CFG_W)
                         ? $clog2(MAX_NODES + 1) : dcd_pkg::CFG_W;
    localparam logic [CNT_W-1:0] N_CNT = CNT_W'(MAX_NODES);

    logic [dcd_pkg::CFG_W-1:0]  r_node_count;
    logic [CNT_W-1:0]           r_limit;
    logic [dcd_pkg::NODE_W-1:0] r_from;
    logic [dcd_pkg::NODE_W-1:0] r_to;
    logic [MAX_NODES-1:0]       r_row_valid;
    logic [MAX_NODES-1:0]       r_visited;
    logic [MAX_NODES-1:0]       r_on_path;
    logic                       r_cycle;
    logic [CNT_W-1:0]           r_start;
    logic [CNT_W-1:0]           r_depth;
    logic [IDX_W-1:0]           r_top;
    logic                       r_rowv;
    logic [MAX_NODES-1:0]       r_cand;
    logic                       r_out_valid;
    logic                       r_out_data;

    logic [CNT_W-1:0]     w_from_ext;
    logic [CNT_W-1:0]     w_to_ext;
    logic [CNT_W-1:0]     w_cnt_ext;
    logic [IDX_W-1:0]     w_from_idx;
    logic [IDX_W-1:0]     w_to_idx;
    logic [IDX_W-1:0]     w_start_idx;
    logic                 w_edge_ok;
    logic [MAX_NODES-1:0] w_to_mask;
    logic [MAX_NODES-1:0] w_adj_rdata;
    logic [MAX_NODES-1:0] w_row;
    logic [IDX_W-1:0]     w_adj_raddr;
    logic [CNT_W-1:0]     w_dm1;
    logic [CNT_W-1:0]     w_dm2;
    logic [IDX_W-1:0]     w_stk_rdata;
    logic [IDX_W-1:0]     w_child;

    assign w_from_ext  = CNT_W'(r_from);
    assign w_to_ext    = CNT_W'(r_to);
    assign w_cnt_ext   = CNT_W'(r_node_count);
    assign w_from_idx  = w_from_ext[IDX_W-1:0];
    assign w_to_idx    = w_to_ext[IDX_W-1:0];
    assign w_start_idx = r_start[IDX_W-1:0];
    assign w_edge_ok   = (w_from_ext < N_CNT) && (w_to_ext < N_CNT);
    assign w_to_mask   = {{(MAX_NODES - 1){1'b0}}, 1'b1} << w_to_idx;
    assign w_row       = r_rowv ? w_adj_rdata : '0;
    assign w_adj_raddr = i_cmd.edge_rd ? w_from_idx : r_top;
    assign w_dm1       = r_depth - CNT_W'(1);
    assign w_dm2       = r_depth - CNT_W'(2);

    // lowest unvisited successor
    always_comb begin
        w_child = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (r_cand[i]) begin
                w_child = IDX_W'(i);
            end
        end
    end

    dcd_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.edge_wr && w_edge_ok),
        .i_waddr (w_from_idx),
        .i_wdata (w_row | w_to_mask),
        .i_re    (i_cmd.edge_rd || i_cmd.row_rd),
        .i_raddr (w_adj_raddr),
        .o_rdata (w_adj_rdata)
    );

    dcd_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_NODES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push_child),
        .i_waddr (w_dm1[IDX_W-1:0]),
        .i_wdata (r_top),
        .i_re    (i_cmd.pop && !o_status.depth_one),
        .i_raddr (w_dm2[IDX_W-1:0]),
        .o_rdata (w_stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= dcd_pkg::NODE_COUNT_RST;
            r_row_valid  <= '0;
            r_visited    <= '0;
            r_on_path    <= '0;
            r_cycle      <= 1'b0;
            r_start      <= '0;
            r_depth      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_data;
            end
            if (i_cmd.edge_wr && w_edge_ok) begin
                r_row_valid[w_from_idx] <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_visited <= '0;
                r_on_path <= '0;
                r_cycle   <= 1'b0;
                r_start   <= '0;
                r_depth   <= '0;
            end
            if (i_cmd.scan_skip) begin
                r_start <= r_start + CNT_W'(1);
            end
            if (i_cmd.scan_push) begin
                r_start                  <= r_start + CNT_W'(1);
                r_visited[w_start_idx]   <= 1'b1;
                r_on_path[w_start_idx]   <= 1'b1;
                r_depth                  <= CNT_W'(1);
            end
            if (i_cmd.row_eval && ((w_row & r_on_path) != '0)) begin
                r_cycle <= 1'b1;
            end
            if (i_cmd.push_child) begin
                r_visited[w_child] <= 1'b1;
                r_on_path[w_child] <= 1'b1;
                r_depth            <= r_depth + CNT_W'(1);
            end
            if (i_cmd.pop) begin
                r_on_path[r_top] <= 1'b0;
                r_depth          <= w_dm1;
            end
            if (i_cmd.load_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_edge) begin
            r_from <= i_edge_from;
            r_to   <= i_edge_to;
        end
        if (i_cmd.clear) begin
            r_limit <= (w_cnt_ext > N_CNT) ? N_CNT : w_cnt_ext;
        end
        if (i_cmd.edge_rd) begin
            r_rowv <= r_row_valid[w_from_idx];
        end
        if (i_cmd.row_rd) begin
            r_rowv <= r_row_valid[r_top];
        end
        if (i_cmd.row_eval) begin
            r_cand <= w_row & ~r_visited;
        end
        if (i_cmd.scan_push) begin
            r_top <= w_start_idx;
        end
        if (i_cmd.push_child) begin
            r_top <= w_child;
        end
        if (i_cmd.pop_load) begin
            r_top <= w_stk_rdata;
        end
        if (i_cmd.load_result) begin
            r_out_data <= r_cycle;
        end
    end

    assign o_status.scan_done     = (r_start >= r_limit);
    assign o_status.start_visited = r_visited[w_start_idx];
    assign o_status.cycle         = r_cycle;
    assign o_status.cand_zero     = (r_cand == '0);
    assign o_status.depth_one     = (r_depth == CNT_W'(1));
    assign o_status.out_free      = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// ----- rtl/core/dcd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dcd_ctrl
// Controller for edge loads and the depth-first cycle check: sequences
// row reads, successor picks, stack pushes and pops, and result hand-off.
// ----------------------------------------------------------------------------
module dcd_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    input  wire logic             i_s_tuser,
    input  wire dcd_pkg::t_status i_status,
    output logic                  o_s_tready,
    output dcd_pkg::t_cmd         o_cmd
);

    dcd_pkg::t_state r_state;
    dcd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dcd_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = (i_s_tuser == dcd_pkg::CMD_CHECK)
                            ? dcd_pkg::S_CLEAR : dcd_pkg::S_EDGE_RD;
                end
            end
            dcd_pkg::S_EDGE_RD:  n_state = dcd_pkg::S_EDGE_WR;
            dcd_pkg::S_EDGE_WR:  n_state = dcd_pkg::S_IDLE;
            dcd_pkg::S_CLEAR:    n_state = dcd_pkg::S_SCAN;
            dcd_pkg::S_SCAN: begin
                if (i_status.scan_done || i_status.cycle) begin
                    n_state = dcd_pkg::S_DONE;
                end else if (!i_status.start_visited) begin
                    n_state = dcd_pkg::S_ROW_RD;
                end
            end
            dcd_pkg::S_ROW_RD:   n_state = dcd_pkg::S_ROW_EVAL;
            dcd_pkg::S_ROW_EVAL: n_state = dcd_pkg::S_PICK;
            dcd_pkg::S_PICK: begin
                if (i_status.cycle) begin
                    n_state = dcd_pkg::S_DONE;
                end else if (!i_status.cand_zero) begin
                    n_state = dcd_pkg::S_ROW_RD;
                end else if (i_status.depth_one) begin
                    n_state = dcd_pkg::S_SCAN;
                end else begin
                    n_state = dcd_pkg::S_POP_WAIT;
                end
            end
            dcd_pkg::S_POP_WAIT: n_state = dcd_pkg::S_ROW_RD;
            dcd_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    n_state = dcd_pkg::S_IDLE;
                end
            end
            default:             n_state = dcd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            dcd_pkg::S_IDLE: begin
                o_s_tready       = i_rst_n;
                o_cmd.latch_edge = i_s_tvalid;
            end
            dcd_pkg::S_EDGE_RD:  o_cmd.edge_rd = 1'b1;
            dcd_pkg::S_EDGE_WR:  o_cmd.edge_wr = 1'b1;
            dcd_pkg::S_CLEAR:    o_cmd.clear   = 1'b1;
            dcd_pkg::S_SCAN: begin
                if (!(i_status.scan_done || i_status.cycle)) begin
                    o_cmd.scan_skip = i_status.start_visited;
                    o_cmd.scan_push = !i_status.start_visited;
                end
            end
            dcd_pkg::S_ROW_RD:   o_cmd.row_rd   = 1'b1;
            dcd_pkg::S_ROW_EVAL: o_cmd.row_eval = 1'b1;
            dcd_pkg::S_PICK: begin
                if (!i_status.cycle) begin
                    o_cmd.pop        = i_status.cand_zero;
                    o_cmd.push_child = !i_status.cand_zero;
                end
            end
            dcd_pkg::S_POP_WAIT: o_cmd.pop_load    = 1'b1;
            dcd_pkg::S_DONE:     o_cmd.load_result = i_status.out_free;
            default: begin
                o_cmd      = '0;
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/directed_cycle_detect.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// directed_cycle_detect
// Directed graph cycle detector: loads edges into an adjacency bit matrix
// and runs a stack-based depth-first walk on request.
// ----------------------------------------------------------------------------
// usage
//   slave stream: tuser is the command (add edge / check), tdata carries
//   edge_from in [5:0] and edge_to in [11:6]; edge fields are ignored on a
//   check. master stream: one transaction per check, tdata[0] = cycle_found.
//   config channel: i_cfg_valid / o_cfg_ready / i_cfg_data writes node_count
//   (nodes 0 .. node_count-1 are walk start nodes); write only while idle.
//   an edge add reads the adjacency row, then writes it back; ready stays
//   low until it is done. a check walks the graph: each row visit costs an
//   adjacency memory read and an evaluate step plus a pick, and each
//   return to a parent adds a stack memory read; it ends early once a
//   cycle is seen.
//   reset clears row valid bits, so the adjacency matrix reads as empty at
//   once; node_count returns to 64. both readies are low during reset.
//   the result sits in an output register; a stalled receiver holds the
//   controller only when a second check result is ready to load.
// ----------------------------------------------------------------------------
module directed_cycle_detect #(
    parameter int MAX_NODES = dcd_pkg::MAX_NODES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    input  wire logic [15:0]               i_s_tdata,  // edge_from, edge_to, zero pad
    input  wire logic                      i_s_tuser,  // command
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    output logic [7:0]                     o_m_tdata,  // cycle_found, zero pad
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [dcd_pkg::CFG_W-1:0] i_cfg_data
);

    dcd_pkg::t_cmd    w_cmd;
    dcd_pkg::t_status w_status;
    logic             w_out_data;

    dcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .i_status   (w_status),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    dcd_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_edge_from (i_s_tdata[5:0]),
        .i_edge_to   (i_s_tdata[11:6]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (w_out_data)
    );

    assign o_m_tdata   = {7'b0, w_out_data};
    assign o_cfg_ready = i_rst_n;

endmodule
`default_nettype wire

// ----- rtl/core/dcd_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dcd_checker
// Port-level checks for the directed cycle detector, bound to the top level.
// ----------------------------------------------------------------------------
module dcd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        i_s_tuser,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [7:0]  o_m_tdata
);

    // result transaction held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");

    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[7:1] == 7'b0))
        else $error("result pad bits not zero");

    // an accepted transaction drops ready in the cycle after it
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready high right after a transaction");

    // an edge add never produces a result
    a_edge_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tuser) |=> !$rose(o_m_tvalid))
        else $error("result after edge add");

endmodule

bind directed_cycle_detect dcd_checker u_dcd_checker (.*);
`default_nettype wire

// ----- tb/dcd_cycle_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcd_cycle_checker
// Watches the edge/check stream, the config channel and the result stream of
// the directed cycle detector. Keeps its own adjacency matrix and node_count,
// runs a depth-first walk for every accepted check and compares each result
// transaction with the oldest predicted cycle_found value.
// ----------------------------------------------------------------------------
module dcd_cycle_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    input  logic [15:0]               i_s_tdata,  // edge_from, edge_to, zero pad
    input  logic                      i_s_tuser,  // command
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    input  logic [7:0]                i_m_tdata,  // cycle_found, zero pad
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [dcd_pkg::CFG_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam int NODES = dcd_pkg::MAX_NODES_DEF;

    logic [NODES-1:0]          adj_rows [NODES];
    logic [dcd_pkg::CFG_W-1:0] node_count_q;
    logic                      cycle_expected_q [$];
    int                        results_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        results_seen = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    // stack-based walk from every unvisited start node below node_count
    function automatic logic graph_has_cycle();
        logic [NODES-1:0] seen;
        logic [NODES-1:0] on_path;
        int               trail [NODES];
        int               cursor [NODES];
        int               depth;
        int               limit;
        int               top;
        int               c;
        logic             hit;
        limit   = (node_count_q > NODES) ? NODES : int'(node_count_q);
        seen    = '0;
        on_path = '0;
        hit     = 1'b0;
        for (int s = 0; s < limit; s++) begin
            if (!seen[s]) begin
                seen[s]    = 1'b1;
                on_path[s] = 1'b1;
                trail[0]   = s;
                cursor[0]  = 0;
                depth      = 1;
                while (depth > 0) begin
                    top = trail[depth-1];
                    c   = cursor[depth-1];
                    if (c >= NODES) begin
                        on_path[top] = 1'b0;
                        depth--;
                    end else begin
                        cursor[depth-1] = c + 1;
                        if (adj_rows[top][c]) begin
                            if (on_path[c]) begin
                                hit = 1'b1;
                            end else if (!seen[c]) begin
                                seen[c]       = 1'b1;
                                on_path[c]    = 1'b1;
                                trail[depth]  = c;
                                cursor[depth] = 0;
                                depth++;
                            end
                        end
                    end
                end
            end
        end
        return hit;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NODES; r++)
                adj_rows[r] = '0;
            node_count_q = dcd_pkg::NODE_COUNT_RST;
            cycle_expected_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                results_seen++;
                if (cycle_expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no check outstanding",
                                              results_seen));
                end else if (i_m_tdata[0] !== cycle_expected_q[0]) begin
                    report_mismatch($sformatf("result %0d cycle_found got %b, expected %b",
                                              results_seen, i_m_tdata[0],
                                              cycle_expected_q[0]));
                    void'(cycle_expected_q.pop_front());
                end else begin
                    void'(cycle_expected_q.pop_front());
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                node_count_q = i_cfg_data;
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == dcd_pkg::CMD_CHECK)
                    cycle_expected_q = {cycle_expected_q, graph_has_cycle()};
                else
                    adj_rows[i_s_tdata[5:0]][i_s_tdata[11:6]] = 1'b1;
            end
        end
        o_pending = cycle_expected_q.size();
    end

endmodule

// ----- tb/directed_cycle_detect_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directed_cycle_detect_tb
// Drives edge loads, checks and node_count writes into the directed cycle
// detector. Cycles are only ever built above a floor node that sinks over
// the run, so checks keep giving both answers; a side checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module directed_cycle_detect_tb;

    localparam int ITEMS            = 1700;
    localparam int SETTLE_CYCLES    = 16;
    localparam int DRAIN_CYCLES     = 600;
    localparam int LONG_HOLD_CYCLES = 4000;
    localparam int TIMEOUT_NS       = 3_000_000;

    logic                      i_clk;
    logic                      i_rst_n     = 1'b0;
    logic                      i_s_tvalid  = 1'b0;
    logic                      o_s_tready;
    logic [15:0]               i_s_tdata   = '0;  // edge_from, edge_to, zero pad
    logic                      i_s_tuser   = dcd_pkg::CMD_ADD_EDGE;  // command
    logic                      o_m_tvalid;
    logic                      i_m_tready  = 1'b0;
    logic [7:0]                o_m_tdata;  // cycle_found, zero pad
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [dcd_pkg::CFG_W-1:0] i_cfg_data  = dcd_pkg::NODE_COUNT_RST;

    int fail_count;
    int expected_left;
    int items_sent    = 0;
    int checks_sent   = 0;
    int cfg_writes    = 0;
    bit calm          = 1'b0;
    bit long_hold_req = 1'b0;

    directed_cycle_detect dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    dcd_cycle_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (expected_left)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    // caller either sends again right away or drops tvalid in the same step
    task automatic send_item(input logic cmd, input logic [5:0] src, input logic [5:0] dst);
        int   gap;
        logic rdy;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {4'b0000, dst, src};
        do begin
            @(negedge i_clk);
            rdy = o_s_tready;
            @(posedge i_clk);
        end while (!rdy);
        items_sent++;
        if (cmd == dcd_pkg::CMD_CHECK)
            checks_sent++;
    endtask

    task automatic settle_and_configure(input logic [dcd_pkg::CFG_W-1:0] value);
        logic rdy;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (expected_left == 0);
        @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    initial begin : result_sink
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 16);
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int         floor_node;
        int         k;
        int         n_edges;
        logic [5:0] src;
        logic [5:0] dst;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty graph, then an acyclic chain with a duplicate edge
        send_item(dcd_pkg::CMD_CHECK, 6'd63, 6'd63);
        send_item(dcd_pkg::CMD_ADD_EDGE, 6'd5, 6'd3);
        send_item(dcd_pkg::CMD_ADD_EDGE, 6'd3, 6'd0);
        send_item(dcd_pkg::CMD_ADD_EDGE, 6'd5, 6'd3);
        send_item(dcd_pkg::CMD_ADD_EDGE, 6'd63, 6'd0);
        send_item(dcd_pkg::CMD_CHECK, 6'd0, 6'd0);
        // self-loop on the top node, checked twice
        send_item(dcd_pkg::CMD_ADD_EDGE, 6'd63, 6'd63);
        send_item(dcd_pkg::CMD_CHECK, 6'd63, 6'd0);
        send_item(dcd_pkg::CMD_CHECK, 6'd21, 6'd42);
        // zero, oversized and boundary node counts
        settle_and_configure(7'd0);
        send_item(dcd_pkg::CMD_CHECK, 6'd63, 6'd63);
        settle_and_configure(7'd127);
        send_item(dcd_pkg::CMD_CHECK, 6'd0, 6'd63);
        settle_and_configure(7'd63);
        send_item(dcd_pkg::CMD_CHECK, 6'd42, 6'd21);
        settle_and_configure(7'd1);
        send_item(dcd_pkg::CMD_CHECK, 6'd1, 6'd1);
        settle_and_configure(7'd65);
        send_item(dcd_pkg::CMD_CHECK, 6'd62, 6'd1);

        // back-to-back checks against a stalled receiver
        settle_and_configure(7'd64);
        long_hold_req = 1'b1;
        repeat (5) send_item(dcd_pkg::CMD_CHECK, 6'($urandom), 6'($urandom));

        while (items_sent < ITEMS) begin
            floor_node = 63 - (items_sent * 64) / ITEMS;
            if (floor_node < 0)
                floor_node = 0;
            calm = (items_sent > ITEMS - ITEMS / 8);
            if ($urandom_range(0, 4) != 0) begin
                case ($urandom_range(0, 9))
                    0: k = 0;
                    1: k = 1;
                    2: k = 64;
                    3: k = $urandom_range(65, 127);
                    default: begin
                        k = floor_node - 2 + int'($urandom_range(0, 8));
                        if (k < 0)
                            k = 0;
                        if (k > 64)
                            k = 64;
                    end
                endcase
                settle_and_configure(k[dcd_pkg::CFG_W-1:0]);
            end
            n_edges = $urandom_range(1, 12);
            repeat (n_edges) begin
                // back edges and self-loops only above the floor
                if ($urandom_range(0, 3) == 0) begin
                    src = 6'($urandom_range(floor_node, 63));
                    dst = 6'($urandom_range(floor_node, 63));
                end else begin
                    src = 6'($urandom_range(1, 63));
                    dst = 6'($urandom_range(0, src - 1));
                end
                send_item(dcd_pkg::CMD_ADD_EDGE, src, dst);
            end
            repeat ($urandom_range(1, 2))
                send_item(dcd_pkg::CMD_CHECK, 6'($urandom), 6'($urandom));
        end
        i_s_tvalid <= 1'b0;

        @(posedge i_clk);
        wait (expected_left == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("run covered %0d stream items (%0d checks) and %0d node_count writes",
                 items_sent, checks_sent, cfg_writes);
        $display("cycle floor swept from node 63 to 0, with one %0d-cycle output stall",
                 LONG_HOLD_CYCLES);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
